>>> rtl/core/ils_pkg.sv
`default_nettype none

package ils_pkg;

	// Store geometry
	localparam int CAPACITY = 1024;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 11;
	localparam int ACT_W    = 3;
	localparam int ST_W     = 2;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (IDX_W > POS_W) ? ((IDX_W > CNT_W) ? IDX_W : CNT_W)
	                                           : ((POS_W > CNT_W) ? POS_W : CNT_W);

	// Read-out tree: cells are OR-reduced in groups, then one group is selected
	localparam int GROUP    = 32;
	localparam int GRP_BITS = $clog2(GROUP);
	localparam int NGROUPS  = CAPACITY / GROUP;

	localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ      = 3'd0,
		ACT_INS_FRONT = 3'd1,
		ACT_APPEND    = 3'd2,
		ACT_INS_AT    = 3'd3,
		ACT_DELETE    = 3'd4
	} act_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RD_A,
		FSM_RD_B
	} fsm_t;

	// Shift command broadcast to every cell
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic [CMP_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/ils_cell.sv
`default_nettype none

module ils_cell (
	input  wire logic                             clk,
	input  wire ils_pkg::cmd_t                    cmd,
	input  wire logic [ils_pkg::IDX_W-1:0]        idx,
	input  wire logic signed [ils_pkg::VAL_W-1:0] lower_val,
	input  wire logic signed [ils_pkg::VAL_W-1:0] upper_val,
	input  wire logic [ils_pkg::IDX_W-1:0]        rd_pos,
	output      logic signed [ils_pkg::VAL_W-1:0] val,
	output      logic signed [ils_pkg::VAL_W-1:0] rd_val
);

	logic [ils_pkg::CMP_W-1:0]        my_idx;
	logic signed [ils_pkg::VAL_W-1:0] val_q;
	logic signed [ils_pkg::VAL_W-1:0] val_d;

	assign my_idx = ils_pkg::CMP_W'(idx);

	// Insert: above the point take from below, at the point take the new value.
	// Delete: at and above the point take from above.
	always_comb begin
		val_d = val_q;
		if (cmd.ins) begin
			if (my_idx > cmd.pos) begin
				val_d = lower_val;
			end else if (my_idx == cmd.pos) begin
				val_d = cmd.value;
			end
		end else if (cmd.del) begin
			if (my_idx >= cmd.pos) begin
				val_d = upper_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val    = val_q;
	assign rd_val = (idx == rd_pos) ? val_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/ils_row.sv
`default_nettype none

module ils_row (
	input  wire logic                      clk,
	input  wire ils_pkg::cmd_t             cmd,
	input  wire logic [ils_pkg::IDX_W-1:0] rd_pos,
	output      logic [ils_pkg::NGROUPS-1:0][ils_pkg::VAL_W-1:0] grp_s1
);

	logic [ils_pkg::CAPACITY-1:0][ils_pkg::VAL_W-1:0] vals;
	logic [ils_pkg::CAPACITY-1:0][ils_pkg::VAL_W-1:0] rd_vals;
	logic [ils_pkg::NGROUPS-1:0][ils_pkg::VAL_W-1:0]  grp_d;

	// Chain of cells, each linked to its neighbors; the end cells take zero beyond the chain
	for (genvar i = 0; i < ils_pkg::CAPACITY; i++) begin : g_cell
		logic signed [ils_pkg::VAL_W-1:0] lower_w;
		logic signed [ils_pkg::VAL_W-1:0] upper_w;

		if (i == 0) begin : g_bot
			assign lower_w = '0;
		end else begin : g_mid_lo
			assign lower_w = vals[i-1];
		end

		if (i == ils_pkg::CAPACITY - 1) begin : g_top
			assign upper_w = '0;
		end else begin : g_mid_hi
			assign upper_w = vals[i+1];
		end

		ils_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.idx       (ils_pkg::IDX_W'(i)),
			.lower_val (lower_w),
			.upper_val (upper_w),
			.rd_pos    (rd_pos),
			.val       (vals[i]),
			.rd_val    (rd_vals[i])
		);
	end

	// Per-group OR of the masked cell outputs; only the addressed cell can be nonzero
	always_comb begin
		for (int g = 0; g < ils_pkg::NGROUPS; g++) begin
			grp_d[g] = '0;
			for (int c = 0; c < ils_pkg::GROUP; c++) begin
				grp_d[g] = grp_d[g] | rd_vals[g*ils_pkg::GROUP + c];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

endmodule

`default_nettype wire

>>> rtl/core/indexed_list_store_core.sv
// Insert, append, delete and out-of-range requests: result strobe in the cycle after
// start; the chain of cells shifts all entries at once, so one transaction per cycle
// while busy is low. Valid reads: address register, registered group OR of the cell
// select, then group select into the result; busy is high in states RD_A and RD_B.
// The receiver cannot stall; done is high for one cycle and the result then holds.
// Reset clears count, state and strobe; values and results undefined until written.
`default_nettype none

module indexed_list_store_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [ils_pkg::ACT_W-1:0]        action,
	input  wire logic [ils_pkg::POS_W-1:0]        position,
	input  wire logic signed [ils_pkg::VAL_W-1:0] item_value,
	output      logic                             busy,
	output      logic                             done,
	output      logic signed [ils_pkg::VAL_W-1:0] read_value,
	output      logic [ils_pkg::ST_W-1:0]         status,
	output      logic [ils_pkg::CNT_W-1:0]        length
);

	ils_pkg::fsm_t                    state_q, state_d;
	logic [ils_pkg::CNT_W-1:0]        count_q, count_d;
	logic [ils_pkg::IDX_W-1:0]        pos_q;
	logic                             done_q;
	logic signed [ils_pkg::VAL_W-1:0] rv_q;
	ils_pkg::status_t                 st_q;
	logic [ils_pkg::CNT_W-1:0]        len_q;

	logic                             accept;
	logic                             go_read;
	logic                             ins_req;
	logic [ils_pkg::CMP_W-1:0]        ins_pos;
	ils_pkg::status_t                 res_st;
	ils_pkg::cmd_t                    cmd;
	logic [ils_pkg::CMP_W-1:0]        pos_c;
	logic [ils_pkg::CMP_W-1:0]        cnt_c;
	logic signed [ils_pkg::VAL_W-1:0] grp_sel;

	logic [ils_pkg::NGROUPS-1:0][ils_pkg::VAL_W-1:0] grp_s1;

	assign accept = start && !busy;
	assign pos_c  = ils_pkg::CMP_W'(position);
	assign cnt_c  = ils_pkg::CMP_W'(count_q);

	// Request decode and shift command
	always_comb begin
		go_read   = 1'b0;
		ins_req   = 1'b0;
		ins_pos   = '0;
		res_st    = ils_pkg::ST_INVALID;
		count_d   = count_q;
		cmd.ins   = 1'b0;
		cmd.del   = 1'b0;
		cmd.pos   = '0;
		cmd.value = item_value;
		if (accept) begin
			unique case (action)
				ils_pkg::ACT_READ: begin
					go_read = (pos_c < cnt_c);
				end
				ils_pkg::ACT_INS_FRONT: begin
					ins_req = 1'b1;
					ins_pos = '0;
				end
				ils_pkg::ACT_APPEND: begin
					ins_req = 1'b1;
					ins_pos = cnt_c;
				end
				ils_pkg::ACT_INS_AT: begin
					ins_req = (pos_c <= cnt_c);
					ins_pos = pos_c;
				end
				ils_pkg::ACT_DELETE: begin
					if (pos_c < cnt_c) begin
						cmd.del = 1'b1;
						cmd.pos = pos_c;
						count_d = count_q - ils_pkg::CNT_W'(1);
						res_st  = ils_pkg::ST_DONE;
					end
				end
				default: begin
				end
			endcase
			if (ins_req) begin
				if (count_q == ils_pkg::CNT_W'(ils_pkg::CAPACITY)) begin
					res_st = ils_pkg::ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					cmd.pos = ins_pos;
					count_d = count_q + ils_pkg::CNT_W'(1);
					res_st  = ils_pkg::ST_DONE;
				end
			end
		end
	end

	ils_row u_row (
		.clk    (clk),
		.cmd    (cmd),
		.rd_pos (pos_q),
		.grp_s1 (grp_s1)
	);

	assign grp_sel = grp_s1[pos_q[ils_pkg::IDX_W-1:ils_pkg::GRP_BITS]];

	// Read sequencer
	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		unique case (state_q)
			ils_pkg::FSM_IDLE: begin
				if (go_read) begin
					state_d = ils_pkg::FSM_RD_A;
				end
			end
			ils_pkg::FSM_RD_A: begin
				busy    = 1'b1;
				state_d = ils_pkg::FSM_RD_B;
			end
			ils_pkg::FSM_RD_B: begin
				busy    = 1'b1;
				state_d = ils_pkg::FSM_IDLE;
			end
			default: begin
				state_d = ils_pkg::FSM_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ils_pkg::FSM_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= (accept && !go_read) || (state_q == ils_pkg::FSM_RD_B);
		end
	end

	// Result and read address registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position[ils_pkg::IDX_W-1:0];
		end
		if (accept && !go_read) begin
			rv_q  <= ils_pkg::NO_VALUE;
			st_q  <= res_st;
			len_q <= count_d;
		end else if (state_q == ils_pkg::FSM_RD_B) begin
			rv_q  <= grp_sel;
			st_q  <= ils_pkg::ST_DONE;
			len_q <= count_q;
		end
	end

	assign done       = done_q;
	assign read_value = rv_q;
	assign status     = st_q;
	assign length     = len_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
		else $error("length above capacity");

	a_count_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(accept))
		else $error("length changed without a transaction");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(accept && !go_read) || $past(state_q == ils_pkg::FSM_RD_B)))
		else $error("result strobe without a source");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && st_q == ils_pkg::ST_FULL) |-> (len_q == ils_pkg::CNT_W'(ils_pkg::CAPACITY)))
		else $error("full status with store not full");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go_read |=> busy ##1 busy)
		else $error("read sequence not held busy");

endmodule

`default_nettype wire
